// ----- src/feistel_lai_massey_block_cipher_assert.svh -----
// Assertion macros used by the cipher top level.
`ifndef FEISTEL_LAI_MASSEY_BLOCK_CIPHER_ASSERT_SVH
`define FEISTEL_LAI_MASSEY_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FLMBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flmbc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FLMBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flmbc: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define FLMBC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("flmbc: reset check failed");

`endif

// ----- src/flmbc_pkg.sv -----
// Types, constants and round functions of the Feistel / Lai-Massey cipher.
package flmbc_pkg;

   localparam int unsigned HALF_W     = 16;
   localparam int unsigned BLOCK_W    = 32;
   localparam int unsigned CSR_W      = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned NUM_ROUNDS = 4;
   localparam int unsigned STAGE_W    = 2;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_KEY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SBOX_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SBOX_HIGH  = 2'd2;

   // Reset values: key zero, identity S-box
   localparam logic [CSR_W-1:0] CIPHER_KEY_RESET = 32'h0000_0000;
   localparam logic [CSR_W-1:0] SBOX_LOW_RESET   = 32'h7654_3210;
   localparam logic [CSR_W-1:0] SBOX_HIGH_RESET  = 32'hFEDC_BA98;

   // Destination of bit i in the bit permutation: (13*i + 7) mod 16
   localparam logic [3:0] BIT_DEST [HALF_W] = '{
      4'd7, 4'd4, 4'd1, 4'd14, 4'd11, 4'd8, 4'd5, 4'd2,
      4'd15, 4'd12, 4'd9, 4'd6, 4'd3, 4'd0, 4'd13, 4'd10
   };

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   // Live configuration seen by the round logic
   typedef struct packed {
      logic [HALF_W-1:0] k1;
      logic [HALF_W-1:0] k2;
      logic [63:0]       sbox;
   } cfg_type;

   // Request handed from the front queue to the round pipeline
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [BLOCK_W-1:0] block;
   } issue_type;

   // Block state inside the round pipeline
   typedef struct packed {
      op_type            op;
      logic [HALF_W-1:0] l;
      logic [HALF_W-1:0] r;
   } stage_type;

   // F(x,k): key mix, four S-box lookups, bit permutation
   function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] k,
                                                  input logic [63:0]       sbox);
      logic [HALF_W-1:0] t;
      logic [HALF_W-1:0] s;
      logic [HALF_W-1:0] p;
      t = x ^ k;
      for (int i = 0; i < 4; i++) begin
         s[4*i +: 4] = sbox[{t[4*i +: 4], 2'b00} +: 4];
      end
      p = '0;
      for (int i = 0; i < HALF_W; i++) begin
         p[BIT_DEST[i]] = s[i];
      end
      return p;
   endfunction

   // One round of the schedule; stage picks which round, op the direction
   function automatic stage_type round_step(input logic [STAGE_W-1:0] stage,
                                            input stage_type           cur,
                                            input cfg_type             cfg);
      stage_type         nxt;
      logic [HALF_W-1:0] f;
      nxt = cur;
      if (cur.op == OP_ENCRYPT) begin
         case (stage)
            2'd0: begin
               // unswapped Feistel, K1
               f     = round_fn(cur.r, cfg.k1, cfg.sbox);
               nxt.l = cur.l ^ f;
            end
            2'd1: begin
               // swapped Feistel, K2
               f     = round_fn(cur.r, cfg.k2, cfg.sbox);
               nxt.l = cur.r;
               nxt.r = cur.l ^ f;
            end
            2'd2: begin
               // Lai-Massey, K1
               f     = round_fn(cur.l ^ cur.r, cfg.k1, cfg.sbox);
               nxt.l = cur.l ^ f;
               nxt.r = cur.r ^ f;
            end
            default: begin
               // Lai-Massey, K2
               f     = round_fn(cur.l ^ cur.r, cfg.k2, cfg.sbox);
               nxt.l = cur.l ^ f;
               nxt.r = cur.r ^ f;
            end
         endcase
      end else begin
         case (stage)
            2'd0: begin
               // Lai-Massey, K2 (self-inverse)
               f     = round_fn(cur.l ^ cur.r, cfg.k2, cfg.sbox);
               nxt.l = cur.l ^ f;
               nxt.r = cur.r ^ f;
            end
            2'd1: begin
               // Lai-Massey, K1
               f     = round_fn(cur.l ^ cur.r, cfg.k1, cfg.sbox);
               nxt.l = cur.l ^ f;
               nxt.r = cur.r ^ f;
            end
            2'd2: begin
               // inverse of swapped Feistel, K2
               f     = round_fn(cur.l, cfg.k2, cfg.sbox);
               nxt.r = cur.l;
               nxt.l = cur.r ^ f;
            end
            default: begin
               // inverse of unswapped Feistel, K1
               f     = round_fn(cur.r, cfg.k1, cfg.sbox);
               nxt.l = cur.l ^ f;
            end
         endcase
      end
      return nxt;
   endfunction

endpackage

// ----- src/feistel_lai_massey_block_cipher.sv -----
// Throughput: one request per cycle while credits are free; rounds run in a 4-stage
// pipeline that never stalls. Sustained rate is set by the result-queue credit loop:
// a credit is held from issue until its result is popped, so OUT_DEPTH >= 6 keeps one
// request per cycle.
// Reset (synchronous): both queues empty, key zero, identity S-box.
module feistel_lai_massey_block_cipher
   import flmbc_pkg::*;
#(
   parameter int unsigned FRONT_DEPTH = 4,
   parameter int unsigned OUT_DEPTH   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_type,
   input  logic [BLOCK_W-1:0]   req_data_block,
   output logic                 empty,
   input  logic                 pop,
   output logic [BLOCK_W-1:0]   rsp_result_block,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [CSR_W-1:0] cipher_key_ff, cipher_key_in;
   logic [CSR_W-1:0] sbox_low_ff, sbox_low_in;
   logic [CSR_W-1:0] sbox_high_ff, sbox_high_in;
   cfg_type          cfg;
   issue_type        issue;
   logic             issue_ready;

   // CSR writes
   always_comb begin
      cipher_key_in = cipher_key_ff;
      sbox_low_in   = sbox_low_ff;
      sbox_high_in  = sbox_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CIPHER_KEY: cipher_key_in = csr_wdata;
            CSR_SBOX_LOW:   sbox_low_in   = csr_wdata;
            CSR_SBOX_HIGH:  sbox_high_in  = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff <= CIPHER_KEY_RESET;
         sbox_low_ff   <= SBOX_LOW_RESET;
         sbox_high_ff  <= SBOX_HIGH_RESET;
      end else begin
         cipher_key_ff <= cipher_key_in;
         sbox_low_ff   <= sbox_low_in;
         sbox_high_ff  <= sbox_high_in;
      end
   end

   assign cfg.k1   = cipher_key_ff[HALF_W-1:0];
   assign cfg.k2   = cipher_key_ff[CSR_W-1:HALF_W];
   assign cfg.sbox = {sbox_high_ff, sbox_low_ff};

   flmbc_front #(
      .DEPTH(FRONT_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_data_block (req_data_block),
      .issue          (issue),
      .issue_ready    (issue_ready)
   );

   flmbc_back #(
      .OUT_DEPTH(OUT_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .issue            (issue),
      .issue_ready      (issue_ready),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_block (rsp_result_block)
   );

   // Checks
`include "feistel_lai_massey_block_cipher_assert.svh"

   `FLMBC_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, empty && !full && !issue.valid)
   `FLMBC_ASSERT_NEXT(a_push_reaches_front, clock, reset, push && !full, issue.valid)
   `FLMBC_ASSERT_NEXT(a_stalled_head_holds, clock, reset, issue.valid && !issue_ready,
                      issue.valid && $stable(issue.block) && $stable(issue.op))

endmodule

// ----- src/flmbc_front.sv -----
// Front end: accepts requests, decodes the operation, queues them for the rounds.
module flmbc_front
   import flmbc_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_type,
   input  logic [BLOCK_W-1:0] req_data_block,
   output issue_type          issue,
   input  logic               issue_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      op_type             op;
      logic [BLOCK_W-1:0] block;
   } entry_type;

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;
   op_type           req_op;

   // Classify the request
   assign req_op = (req_type == 1'b1) ? OP_DECRYPT : OP_ENCRYPT;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign push_fire = push && !full;
   assign pop_fire  = issue.valid && issue_ready;

   // Head of queue toward the round pipeline
   assign issue.valid = (count_ff != '0);
   assign issue.op    = mem_ff[rd_ptr_ff].op;
   assign issue.block = mem_ff[rd_ptr_ff].block;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!push_fire && pop_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= '{op: req_op, block: req_data_block};
      end
   end

endmodule

// ----- src/flmbc_back.sv -----
// Back end: four-stage round pipeline with a credit-managed result queue.
module flmbc_back
   import flmbc_pkg::*;
#(
   parameter int unsigned OUT_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  issue_type          issue,
   output logic               issue_ready,
   output logic               empty,
   input  logic               pop,
   output logic [BLOCK_W-1:0] rsp_result_block
);

   localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

   stage_type          stage_ff    [NUM_ROUNDS];
   stage_type          stage_in    [NUM_ROUNDS];
   logic [NUM_ROUNDS-1:0] valid_ff, valid_in;
   logic [BLOCK_W-1:0] mem_ff      [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   credit_ff, credit_in;
   logic               issue_fire;
   logic               wr_fire;
   logic               pop_fire;
   stage_type          head;

   // Credits cover every request in flight plus every queued result
   assign issue_ready = (credit_ff < CNT_W'(OUT_DEPTH));
   assign issue_fire  = issue.valid && issue_ready;
   assign pop_fire    = pop && !empty;
   assign wr_fire     = valid_ff[NUM_ROUNDS-1];

   assign head = '{op: issue.op, l: issue.block[HALF_W-1:0],
                   r: issue.block[BLOCK_W-1:HALF_W]};

   // One round per stage; the pipeline never stalls
   always_comb begin
      stage_in[0] = round_step(STAGE_W'(0), head, cfg);
      valid_in[0] = issue_fire;
      for (int i = 1; i < NUM_ROUNDS; i++) begin
         stage_in[i] = round_step(STAGE_W'(i), stage_ff[i-1], cfg);
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ROUNDS; i++) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   // Result queue pointers, count and credits
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      credit_in = credit_ff;
      if (wr_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_fire && pop_fire) begin
         count_in = count_ff - 1'b1;
      end
      if (issue_fire && !pop_fire) begin
         credit_in = credit_ff + 1'b1;
      end else if (!issue_fire && pop_fire) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem_ff[wr_ptr_ff] <= {stage_ff[NUM_ROUNDS-1].r, stage_ff[NUM_ROUNDS-1].l};
      end
   end

   assign empty            = (count_ff == '0);
   assign rsp_result_block = mem_ff[rd_ptr_ff];

endmodule

// ----- test/feistel_lai_massey_block_cipher_tb.sv -----
// Self-checking testbench for the four-round Feistel / Lai-Massey block cipher.
module feistel_lai_massey_block_cipher_tb
   import flmbc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES     = 8;
   localparam int REQ_PER_PHASE  = 194;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 12;
   localparam int MAX_REPORTS    = 10;
   localparam int PERM_MUL       = 13;
   localparam int PERM_ADD       = 7;

   // index with no register behind it; writes must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 2'd3;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_PREDICT,
      ROW_FIXED
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_W-1:0]     wdata;
      op_type               op;
      logic [BLOCK_W-1:0]   blk;
      logic [BLOCK_W-1:0]   result;
   } dir_row_type;

   typedef struct packed {
      op_type             op;
      logic [BLOCK_W-1:0] source;
      logic [BLOCK_W-1:0] result;
   } cipher_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 push;
   logic                 full;
   logic                 req_type;
   logic [BLOCK_W-1:0]   req_data_block;
   logic                 empty;
   logic                 pop;
   logic [BLOCK_W-1:0]   rsp_result_block;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // expected value for directed rows whose result is typed in
   logic                 req_fixed_valid;
   logic [BLOCK_W-1:0]   req_fixed_result;

   // shadow copy of the configuration registers
   logic [CSR_W-1:0]     key_shadow       = CIPHER_KEY_RESET;
   logic [CSR_W-1:0]     sbox_low_shadow  = SBOX_LOW_RESET;
   logic [CSR_W-1:0]     sbox_high_shadow = SBOX_HIGH_RESET;

   cipher_result_type    pending_results [$];
   dir_row_type          directed_rows [$];

   int  failure_count     = 0;
   int  requests_accepted = 0;
   int  results_checked   = 0;
   int  csr_writes        = 0;
   int  idle_cycles       = 0;
   int  burst_left        = 0;
   int  rx_run_left       = 0;
   bit  rx_level          = 1'b1;
   bit  steady            = 1'b0;

   feistel_lai_massey_block_cipher dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_data_block   (req_data_block),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_block (rsp_result_block),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // key mix, nibble substitution, bit scatter to (13i+7) mod 16
   function automatic logic [HALF_W-1:0] mix_halfword(input logic [HALF_W-1:0] x,
                                                      input logic [HALF_W-1:0] k,
                                                      input logic [CSR_W-1:0]  lo,
                                                      input logic [CSR_W-1:0]  hi);
      logic [HALF_W-1:0] t;
      logic [HALF_W-1:0] s;
      logic [HALF_W-1:0] p;
      logic [3:0]        nib;
      t = x ^ k;
      for (int i = 0; i < 4; i++) begin
         nib = t[4*i +: 4];
         s[4*i +: 4] = nib[3] ? hi[{nib[2:0], 2'b00} +: 4] : lo[{nib[2:0], 2'b00} +: 4];
      end
      p = '0;
      for (int i = 0; i < HALF_W; i++) begin
         p[(PERM_MUL * i + PERM_ADD) % HALF_W] = s[i];
      end
      return p;
   endfunction

   // full four-round transform of one block under the given configuration
   function automatic logic [BLOCK_W-1:0] cipher_predict(input op_type             op,
                                                         input logic [BLOCK_W-1:0] blk,
                                                         input logic [CSR_W-1:0]   key,
                                                         input logic [CSR_W-1:0]   lo,
                                                         input logic [CSR_W-1:0]   hi);
      logic [HALF_W-1:0] l;
      logic [HALF_W-1:0] r;
      logic [HALF_W-1:0] k1;
      logic [HALF_W-1:0] k2;
      logic [HALF_W-1:0] t;
      l  = blk[HALF_W-1:0];
      r  = blk[BLOCK_W-1:HALF_W];
      k1 = key[HALF_W-1:0];
      k2 = key[CSR_W-1:HALF_W];
      if (op == OP_ENCRYPT) begin
         l = l ^ mix_halfword(r, k1, lo, hi);
         t = l ^ mix_halfword(r, k2, lo, hi);
         l = r;
         r = t;
         t = mix_halfword(l ^ r, k1, lo, hi);
         l = l ^ t;
         r = r ^ t;
         t = mix_halfword(l ^ r, k2, lo, hi);
         l = l ^ t;
         r = r ^ t;
      end else begin
         t = mix_halfword(l ^ r, k2, lo, hi);
         l = l ^ t;
         r = r ^ t;
         t = mix_halfword(l ^ r, k1, lo, hi);
         l = l ^ t;
         r = r ^ t;
         t = r ^ mix_halfword(l, k2, lo, hi);
         r = l;
         l = t ^ mix_halfword(r, k1, lo, hi);
      end
      return {r, l};
   endfunction

   // random permutation of 0..15 packed as {sbox_high, sbox_low}
   function automatic logic [2*CSR_W-1:0] random_bijective_sbox();
      int                 perm [16];
      int                 j;
      int                 tmp;
      logic [2*CSR_W-1:0] packed_sbox;
      for (int v = 0; v < 16; v++) perm[v] = v;
      for (int v = 15; v > 0; v--) begin
         j       = $urandom_range(v, 0);
         tmp     = perm[v];
         perm[v] = perm[j];
         perm[j] = tmp;
      end
      for (int v = 0; v < 16; v++) packed_sbox[4*v +: 4] = perm[v][3:0];
      return packed_sbox;
   endfunction

   function automatic dir_row_type row_cfg(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_W-1:0]     val);
      return '{ROW_CFG, idx, val, OP_ENCRYPT, '0, '0};
   endfunction

   function automatic dir_row_type row_predict(input op_type op,
                                               input logic [BLOCK_W-1:0] blk);
      return '{ROW_PREDICT, CSR_CIPHER_KEY, '0, op, blk, '0};
   endfunction

   function automatic dir_row_type row_fixed(input op_type             op,
                                             input logic [BLOCK_W-1:0] blk,
                                             input logic [BLOCK_W-1:0] res);
      return '{ROW_FIXED, CSR_CIPHER_KEY, '0, op, blk, res};
   endfunction

   // offer one request in bursts with random gaps; returns at a falling edge
   task automatic send_block(input op_type             op,
                             input logic [BLOCK_W-1:0] blk,
                             input logic               fixed_valid,
                             input logic [BLOCK_W-1:0] fixed_result);
      int gap;
      if (burst_left == 0) begin
         burst_left = steady ? 1000 : $urandom_range(40, 1);
         gap        = steady ? 0 : $urandom_range(8, 0);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push             <= 1'b1;
      req_type         <= op;
      req_data_block   <= blk;
      req_fixed_valid  <= fixed_valid;
      req_fixed_result <= fixed_result;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // wait for the block to go idle, then write one register
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      push <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      burst_left = 0;
   endtask

   // receiver: pop held high in steady mode, else runs of pop high and pop low of random length
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (steady) begin
         pop <= 1'b1;
      end else begin
         if (rx_run_left == 0) begin
            rx_level    = ($urandom_range(3, 0) != 0);
            rx_run_left = rx_level ? $urandom_range(30, 1) : $urandom_range(12, 1);
         end
         rx_run_left--;
         pop <= rx_level;
      end
   end

   // monitor: shadow registers, expectations on request, compare on result
   always @(posedge clock) begin : monitor
      cipher_result_type item;
      if (reset) begin
         key_shadow       = CIPHER_KEY_RESET;
         sbox_low_shadow  = SBOX_LOW_RESET;
         sbox_high_shadow = SBOX_HIGH_RESET;
      end else begin
         if (csr_wr_en) begin
            csr_writes++;
            case (csr_index)
               CSR_CIPHER_KEY: key_shadow       = csr_wdata;
               CSR_SBOX_LOW:   sbox_low_shadow  = csr_wdata;
               CSR_SBOX_HIGH:  sbox_high_shadow = csr_wdata;
               default: ;
            endcase
         end
         if (push && !full) begin
            item.op     = op_type'(req_type);
            item.source = req_data_block;
            item.result = req_fixed_valid ? req_fixed_result :
                          cipher_predict(item.op, req_data_block, key_shadow,
                                         sbox_low_shadow, sbox_high_shadow);
            pending_results.insert(pending_results.size(), item);
            requests_accepted++;
         end
         if (pop && !empty) begin
            if (pending_results.size() == 0) begin
               failure_count++;
               if (failure_count <= MAX_REPORTS)
                  $display("%0t: result %h with no request pending", $realtime,
                           rsp_result_block);
            end else begin
               item = pending_results.pop_front();
               results_checked++;
               if (rsp_result_block !== item.result) begin
                  failure_count++;
                  if (failure_count <= MAX_REPORTS)
                     $display("%0t: %s of %h: expected %h, got %h", $realtime,
                              item.op.name(), item.source, item.result, rsp_result_block);
               end
            end
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("No request or result moved for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      op_type             op;
      op_type             fwd_op;
      logic [BLOCK_W-1:0] blk;
      logic [CSR_W-1:0]   key_val;
      logic [CSR_W-1:0]   lo_val;
      logic [CSR_W-1:0]   hi_val;
      logic [2*CSR_W-1:0] perm_sbox;
      int                 mode;

      reset            = 1'b1;
      push             = 1'b0;
      req_type         = OP_ENCRYPT;
      req_data_block   = '0;
      req_fixed_valid  = 1'b0;
      req_fixed_result = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_CIPHER_KEY;
      csr_wdata        = '0;

      // zero key and identity S-box first: all-zero and all-one blocks map to themselves;
      // an all-zero S-box makes both directions a plain half swap
      directed_rows = '{
         row_fixed(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000),
         row_fixed(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000),
         row_fixed(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
         row_fixed(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
         row_predict(OP_ENCRYPT, 32'h0000_FFFF),
         row_predict(OP_DECRYPT, 32'hFFFF_0000),
         row_predict(OP_ENCRYPT, 32'h1234_5678),
         row_cfg(CSR_CIPHER_KEY, 32'hFFFF_FFFF),
         row_predict(OP_ENCRYPT, 32'h0000_0000),
         row_predict(OP_DECRYPT, 32'hFFFF_FFFF),
         row_predict(OP_ENCRYPT, 32'h0000_FFFF),
         row_predict(OP_DECRYPT, 32'h8000_0001),
         row_cfg(CSR_SBOX_LOW, 32'h0000_0000),
         row_cfg(CSR_SBOX_HIGH, 32'h0000_0000),
         row_fixed(OP_ENCRYPT, 32'h1234_ABCD, 32'hABCD_1234),
         row_fixed(OP_DECRYPT, 32'hFFFF_0000, 32'h0000_FFFF),
         row_cfg(CSR_SBOX_LOW, 32'hFFFF_FFFF),
         row_cfg(CSR_SBOX_HIGH, 32'hFFFF_FFFF),
         row_predict(OP_ENCRYPT, 32'h1357_9BDF),
         row_predict(OP_DECRYPT, 32'h2468_ACE0),
         row_cfg(CSR_NO_REG, 32'hDEAD_BEEF),
         row_predict(OP_ENCRYPT, 32'h0F0F_0F0F),
         row_cfg(CSR_CIPHER_KEY, 32'hA5A5_0F0F),
         row_cfg(CSR_SBOX_LOW, 32'h89AB_CDEF),
         row_cfg(CSR_SBOX_HIGH, 32'h0123_4567),
         row_predict(OP_ENCRYPT, 32'h0001_0000),
         row_predict(OP_DECRYPT, 32'h0000_0001)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[n]) begin
         case (directed_rows[n].kind)
            ROW_CFG:   write_csr(directed_rows[n].idx, directed_rows[n].wdata);
            ROW_FIXED: send_block(directed_rows[n].op, directed_rows[n].blk, 1'b1,
                                  directed_rows[n].result);
            default:   send_block(directed_rows[n].op, directed_rows[n].blk, 1'b0, '0);
         endcase
      end

      // random phases, each under its own configuration
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               key_val = CIPHER_KEY_RESET;
               lo_val  = SBOX_LOW_RESET;
               hi_val  = SBOX_HIGH_RESET;
            end
            1: begin
               key_val = 32'hFFFF_FFFF;
               lo_val  = 32'hFFFF_FFFF;
               hi_val  = 32'hFFFF_FFFF;
            end
            2: begin
               key_val = $urandom;
               lo_val  = $urandom;
               hi_val  = $urandom;
            end
            default: begin
               key_val   = $urandom;
               perm_sbox = random_bijective_sbox();
               lo_val    = perm_sbox[CSR_W-1:0];
               hi_val    = perm_sbox[2*CSR_W-1:CSR_W];
            end
         endcase
         if (phase >= 4) write_csr(CSR_NO_REG, $urandom);
         write_csr(CSR_CIPHER_KEY, key_val);
         write_csr(CSR_SBOX_LOW, lo_val);
         write_csr(CSR_SBOX_HIGH, hi_val);
         steady = (phase == 3);

         for (int n = 0; n < REQ_PER_PHASE; n++) begin
            mode = $urandom_range(7, 0);
            op   = op_type'($urandom_range(1, 0));
            blk  = $urandom;
            if (mode == 0) begin
               case ($urandom_range(3, 0))
                  0:       blk = 32'h0000_0000;
                  1:       blk = 32'hFFFF_FFFF;
                  2:       blk = 32'h0000_FFFF;
                  default: blk = 32'hFFFF_0000;
               endcase
            end else if (mode <= 3) begin
               // round trip: feed back the transform of a random block the other way
               fwd_op = op;
               blk    = cipher_predict(fwd_op, $urandom, key_shadow, sbox_low_shadow,
                                       sbox_high_shadow);
               op     = (fwd_op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
            end
            send_block(op, blk, 1'b0, '0);
         end
      end

      // drain, then allow for the pipeline latency
      push <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Run covered %0d requests (encrypt and decrypt) over %0d key/S-box settings,",
               requests_accepted, NUM_PHASES + 5);
      $display("%0d register writes, %0d results compared, %0d failures.",
               csr_writes, results_checked, failure_count);
      if (failure_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/flmbc_pkg.sv
src/flmbc_front.sv
src/flmbc_back.sv
src/feistel_lai_massey_block_cipher.sv
test/feistel_lai_massey_block_cipher_tb.sv
